// File: rtl/sst_pkg.sv
// Package for the socket slot state table: sizes, operation, status and slot
// state codes, the slot record and the controller-to-datapath command bundle.
// Used by every module of the block except sst_ram; depends on nothing.
package sst_pkg;

	// Number of socket slots and the width of a slot number
	localparam int unsigned SLOT_COUNT = 16;
	localparam int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Input field widths
	localparam int unsigned OP_W    = 3;
	localparam int unsigned OWNER_W = 32;
	localparam int unsigned SIDX_W  = 5;
	localparam int unsigned FAM_W   = 2;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned STACK_W = 32;
	localparam int unsigned PORT_W  = 16;
	localparam int unsigned ADDR_W  = 32;

	// Output field widths
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OPENED_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_OPEN    = 3'd0,
		OP_BIND    = 3'd1,
		OP_CONNECT = 3'd2,
		OP_LISTEN  = 3'd3,
		OP_CLOSE   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK      = 2'd0,
		RES_INVALID = 2'd1,
		RES_NO_SLOT = 2'd2,
		RES_DENIED  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SS_FREE       = 3'd0,
		SS_OPEN       = 3'd1,
		SS_BOUND      = 3'd2,
		SS_CONNECTING = 3'd3,
		SS_CONNECTED  = 3'd4,
		SS_LISTENING  = 3'd5
	} slot_state_t;

	// Family and kind codes as stored in a slot
	localparam logic FAM_IPV4    = 1'b0;
	localparam logic KIND_STREAM = 1'b0;

	// One slot as held in the slot memory
	typedef struct packed {
		slot_state_t         state;
		logic [OWNER_W-1:0]  owner;
		logic                family;
		logic                kind;
		logic [STACK_W-1:0]  stack;
		logic [PORT_W-1:0]   bind_port;
		logic [ADDR_W-1:0]   local_addr;
		logic [PORT_W-1:0]   peer_port;
		logic [ADDR_W-1:0]   remote_addr;
	} slot_rec_t;

	localparam int unsigned REC_W = $bits(slot_rec_t);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture a transaction and start the slot read
		logic commit;  // decide, write back and load the result register
	} dp_cmd_t;

endpackage

// File: rtl/sst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the slot record store.
module sst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; hold data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/sst_ctrl.sv
// Controller of the socket slot state table: input and output handshakes and
// the two-state sequence that drives the datapath. Depends on sst_pkg.
module sst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output sst_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		CS_IDLE = 2'b01,
		CS_EXEC = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        accept;
	logic        out_free;
	logic        commit;

	// Handshake decode
	assign in_stall  = (state_q != CS_IDLE);
	assign accept    = in_valid && (state_q == CS_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign commit    = (state_q == CS_EXEC) && out_free;
	assign out_valid = out_valid_q;

	assign cmd.load   = accept;
	assign cmd.commit = commit;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (accept) begin
					state_nxt = CS_EXEC;
				end
			end
			CS_EXEC: begin
				if (commit) begin
					state_nxt = CS_IDLE;
				end
			end
			default: state_nxt = CS_IDLE;
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the result valid until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == CS_EXEC))
		else $error("accepted transaction did not enter execute");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed transaction produced no result");

	a_wait_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_EXEC) && out_valid_q && out_stall |=> (state_q == CS_EXEC))
		else $error("execute finished while result register was still full");

	a_no_commit_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_IDLE) |-> !commit)
		else $error("commit outside execute");

endmodule

// File: rtl/sst_dp.sv
// Datapath of the socket slot state table: transaction capture, free-slot
// search, slot record read-modify-write, occupancy bits and result register.
// Depends on sst_pkg and sst_ram.
module sst_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sst_pkg::dp_cmd_t               cmd,
	input  logic [sst_pkg::OP_W-1:0]       operation,
	input  logic [sst_pkg::OWNER_W-1:0]    owner,
	input  logic [sst_pkg::SIDX_W-1:0]     slot_index,
	input  logic                           descriptor_ok,
	input  logic [sst_pkg::FAM_W-1:0]      addr_family,
	input  logic [sst_pkg::KIND_W-1:0]     sock_kind,
	input  logic [sst_pkg::STACK_W-1:0]    stack_select,
	input  logic [sst_pkg::PORT_W-1:0]     port_number,
	input  logic [sst_pkg::ADDR_W-1:0]     ipv4_address,
	output logic [sst_pkg::STATUS_W-1:0]   status,
	output logic [sst_pkg::OPENED_W-1:0]   opened_slot
);

	// Captured transaction
	logic [sst_pkg::OP_W-1:0]    op_s1;
	logic [sst_pkg::OWNER_W-1:0] owner_s1;
	logic                        fields_ok_s1;
	logic                        family_s1;
	logic                        kind_s1;
	logic [sst_pkg::STACK_W-1:0] stack_s1;
	logic [sst_pkg::PORT_W-1:0]  port_s1;
	logic [sst_pkg::ADDR_W-1:0]  addr_s1;
	logic                        in_range_s1;
	logic                        free_found_s1;
	logic [sst_pkg::IDX_W-1:0]   slot_s1;

	// Occupancy: a slot that is not busy reads as an all-zero (free) record
	logic [sst_pkg::SLOT_COUNT-1:0] busy_q;

	logic [sst_pkg::IDX_W-1:0]   free_idx;
	logic                        free_found;
	logic [sst_pkg::IDX_W-1:0]   rd_slot;
	logic                        in_range;
	logic [sst_pkg::REC_W-1:0]   rd_word;
	sst_pkg::slot_rec_t          cur;
	sst_pkg::slot_rec_t          nxt;
	logic                        owned;
	logic                        wr_req;
	logic                        set_busy;
	logic                        clr_busy;
	sst_pkg::status_t            res;
	logic [31:0]                 slot_wide;

	// Find the lowest free slot
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = sst_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_idx   = sst_pkg::IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	// Pick the slot to read: lowest free for open, the named slot otherwise (slot 0 if out of range)
	assign in_range = (32'(slot_index) < 32'(sst_pkg::SLOT_COUNT));
	always_comb begin
		if (sst_pkg::op_t'(operation) == sst_pkg::OP_OPEN) begin
			rd_slot = free_idx;
		end else if (in_range) begin
			rd_slot = sst_pkg::IDX_W'(32'(slot_index));
		end else begin
			rd_slot = '0;
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1         <= operation;
			owner_s1      <= owner;
			fields_ok_s1  <= (owner != '0) && descriptor_ok
				&& (addr_family[sst_pkg::FAM_W-1:1] == '0)
				&& (sock_kind[sst_pkg::KIND_W-1:1] == '0);
			family_s1     <= addr_family[0];
			kind_s1       <= sock_kind[0];
			stack_s1      <= stack_select;
			port_s1       <= port_number;
			addr_s1       <= ipv4_address;
			in_range_s1   <= in_range;
			free_found_s1 <= free_found;
			slot_s1       <= rd_slot;
		end
	end

	sst_ram #(
		.WIDTH (sst_pkg::REC_W),
		.DEPTH (sst_pkg::SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (cmd.commit && wr_req),
		.wr_addr (slot_s1),
		.wr_data (nxt),
		.rd_en   (cmd.load),
		.rd_addr (rd_slot),
		.rd_data (rd_word)
	);

	// Mask records of slots that were never opened or have been closed
	assign cur = busy_q[slot_s1] ? sst_pkg::slot_rec_t'(rd_word) : '0;

	assign owned = (owner_s1 != '0) && in_range_s1 && busy_q[slot_s1]
		&& (cur.state != sst_pkg::SS_FREE) && (cur.owner == owner_s1);

	// Decide the operation and build the new record
	always_comb begin
		nxt      = cur;
		wr_req   = 1'b0;
		set_busy = 1'b0;
		clr_busy = 1'b0;
		res      = sst_pkg::RES_INVALID;
		case (sst_pkg::op_t'(op_s1))
			sst_pkg::OP_OPEN: begin
				if (!fields_ok_s1) begin
					res = sst_pkg::RES_INVALID;
				end else if (!free_found_s1) begin
					res = sst_pkg::RES_NO_SLOT;
				end else begin
					nxt        = '0;
					nxt.state  = sst_pkg::SS_OPEN;
					nxt.owner  = owner_s1;
					nxt.family = family_s1;
					nxt.kind   = kind_s1;
					nxt.stack  = stack_s1;
					wr_req     = 1'b1;
					set_busy   = 1'b1;
					res        = sst_pkg::RES_OK;
				end
			end
			sst_pkg::OP_BIND: begin
				if (owned && (cur.state == sst_pkg::SS_OPEN)) begin
					nxt.bind_port  = port_s1;
					nxt.local_addr = addr_s1;
					nxt.state      = sst_pkg::SS_BOUND;
					wr_req         = 1'b1;
					res            = sst_pkg::RES_OK;
				end
			end
			sst_pkg::OP_CONNECT: begin
				if (owned && ((cur.state == sst_pkg::SS_OPEN)
					|| (cur.state == sst_pkg::SS_BOUND))) begin
					nxt.peer_port   = port_s1;
					nxt.remote_addr = addr_s1;
					nxt.state       = (cur.kind == sst_pkg::KIND_STREAM)
						? sst_pkg::SS_CONNECTING : sst_pkg::SS_CONNECTED;
					wr_req          = 1'b1;
					res             = sst_pkg::RES_OK;
				end
			end
			sst_pkg::OP_LISTEN: begin
				if (owned && (cur.kind == sst_pkg::KIND_STREAM)
					&& (cur.state == sst_pkg::SS_BOUND)) begin
					nxt.state = sst_pkg::SS_LISTENING;
					wr_req    = 1'b1;
					res       = sst_pkg::RES_OK;
				end
			end
			sst_pkg::OP_CLOSE: begin
				if (owned) begin
					nxt      = '0;
					wr_req   = 1'b1;
					clr_busy = 1'b1;
					res      = sst_pkg::RES_OK;
				end else begin
					res = sst_pkg::RES_DENIED;
				end
			end
			default: res = sst_pkg::RES_INVALID;
		endcase
	end

	// Update occupancy on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (cmd.commit) begin
			if (set_busy) begin
				busy_q[slot_s1] <= 1'b1;
			end else if (clr_busy) begin
				busy_q[slot_s1] <= 1'b0;
			end
		end
	end

	// Load the result register
	assign slot_wide = 32'(slot_s1);
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= res;
			opened_slot <= set_busy ? slot_wide[sst_pkg::OPENED_W-1:0] : '0;
		end
	end

endmodule

// File: rtl/socket_slot_state_table.sv
// Top level of the socket slot state table: controller and datapath.
// Depends on sst_pkg, sst_ctrl, sst_dp (and through it sst_ram).
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | operation, owner, slot_index, descriptor_ok,
//          |                      | addr_family, sock_kind, stack_select,
//          |                      | port_number, ipv4_address
//  out     | out_valid / out_stall| status, opened_slot
//
// Each transaction first picks the slot (lowest free slot for open) and reads
// its record from the slot RAM as it is taken, then decides and writes it back
// in execute, which waits while the output register is still full.
// Reset clears the occupancy bits at once, so every slot reads as free; the
// slot RAM needs no clearing pass.
// A result waits in the output register while out_stall is high; the next
// transaction is taken meanwhile and holds in execute until the register frees.
module socket_slot_state_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sst_pkg::OP_W-1:0]       operation,
	input  logic [sst_pkg::OWNER_W-1:0]    owner,
	input  logic [sst_pkg::SIDX_W-1:0]     slot_index,
	input  logic                           descriptor_ok,
	input  logic [sst_pkg::FAM_W-1:0]      addr_family,
	input  logic [sst_pkg::KIND_W-1:0]     sock_kind,
	input  logic [sst_pkg::STACK_W-1:0]    stack_select,
	input  logic [sst_pkg::PORT_W-1:0]     port_number,
	input  logic [sst_pkg::ADDR_W-1:0]     ipv4_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sst_pkg::STATUS_W-1:0]   status,
	output logic [sst_pkg::OPENED_W-1:0]   opened_slot
);

	sst_pkg::dp_cmd_t cmd;

	sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sst_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.owner         (owner),
		.slot_index    (slot_index),
		.descriptor_ok (descriptor_ok),
		.addr_family   (addr_family),
		.sock_kind     (sock_kind),
		.stack_select  (stack_select),
		.port_number   (port_number),
		.ipv4_address  (ipv4_address),
		.status        (status),
		.opened_slot   (opened_slot)
	);

endmodule
